@@ rtl/bhs_pkg.sv @@
// Package for the bilinear height sampler: field widths, register indexes,
// request codes and reset values shared by the sampler's modules.
// Depends on nothing.
`default_nettype none

package bhs_pkg;

    // Field widths
    localparam int POS_W    = 24;
    localparam int FRAC_W   = 8;
    localparam int HEIGHT_W = 16;
    localparam int OUT_W    = 24;
    localparam int SIZE_W   = 9;
    localparam int CELL_W   = 16;
    localparam int CFG_W    = 16;
    localparam int CFG_IDX_W = 2;

    // Internal arithmetic widths
    localparam int AXIS_W = 18;               // signed room for clamp math
    localparam int WGT_W  = FRAC_W + 1;       // one-axis weight, 0..256
    localparam int WXY_W  = 2 * FRAC_W + 1;   // two-axis weight, 0..65536
    localparam int PROD_W = HEIGHT_W + WXY_W + 1;
    localparam int SUM_W  = PROD_W + 2;

    // Default raster bounds
    localparam int MAX_COLS_DEF = 256;
    localparam int MAX_ROWS_DEF = 256;

    // Request codes
    localparam logic REQ_WRITE  = 1'b0;
    localparam logic REQ_SAMPLE = 1'b1;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_COLS   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ROWS   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_NODATA = 2'd2;

    // Reset values and thresholds
    localparam logic [SIZE_W-1:0]          SIZE_RESET   = 9'd256;
    localparam logic signed [HEIGHT_W-1:0] NODATA_RESET = -16'sd32767;
    localparam logic signed [HEIGHT_W-1:0] MIN_VALID    = -16'sd32000;

    localparam logic [WGT_W-1:0] WGT_ONE = WGT_W'(1) << FRAC_W;
    localparam logic signed [SUM_W-1:0] ROUND_HALF = SUM_W'(1) <<< (FRAC_W - 1);

endpackage

`default_nettype wire

@@ rtl/bilinear_height_sampler_core.sv @@
// Bilinear height sampler with nodata handling: raster load and sample
// pipeline. Depends on bhs_pkg, bhs_axis and bhs_store.
// A sample passes the stage 1, store read, product and output registers before done.
// Throughput: one beat (write or sample) per cycle; busy stays low, since the
// two-bank raster store serves all four neighbors in a single access.
// Results cannot be stalled: done marks height_out for exactly one cycle.
// Reset: configuration returns to 256 x 256 and nodata -32767, the pipeline
// empties; raster contents stay undefined until written (no clearing pass).
`default_nettype none

module bilinear_height_sampler_core
    import bhs_pkg::*;
#(
    parameter int MAX_COLS = MAX_COLS_DEF,
    parameter int MAX_ROWS = MAX_ROWS_DEF
)
(
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        start,
    output logic                             busy,
    input  wire logic                        req_type,
    input  wire logic [CELL_W-1:0]           cell_index,
    input  wire logic signed [HEIGHT_W-1:0]  cell_height,
    input  wire logic signed [POS_W-1:0]     sample_col,
    input  wire logic signed [POS_W-1:0]     sample_row,
    input  wire logic                        cfg_we,
    input  wire logic [CFG_IDX_W-1:0]        cfg_index,
    input  wire logic [CFG_W-1:0]            cfg_data,
    output logic                             done,
    output logic signed [OUT_W-1:0]          height_out
);

    localparam int CIW = $clog2(MAX_COLS);
    localparam int RIW = $clog2(MAX_ROWS);
    localparam int CCW = $clog2(MAX_COLS + 1);
    localparam int RCW = $clog2(MAX_ROWS + 1);
    localparam int STORE_DEPTH = MAX_COLS * MAX_ROWS;
    localparam int IDX_W = $clog2(STORE_DEPTH);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [SIZE_W-1:0]          raster_cols_reg;
    logic [SIZE_W-1:0]          raster_rows_reg;
    logic signed [HEIGHT_W-1:0] nodata_value_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            raster_cols_reg  <= SIZE_RESET;
            raster_rows_reg  <= SIZE_RESET;
            nodata_value_reg <= NODATA_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_COLS:   raster_cols_reg  <= cfg_data[SIZE_W-1:0];
                REG_ROWS:   raster_rows_reg  <= cfg_data[SIZE_W-1:0];
                REG_NODATA: nodata_value_reg <= signed'(cfg_data[HEIGHT_W-1:0]);
                default:    ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Accept stage: clamp both axes straight off the input beat
    // ------------------------------------------------------------------
    logic accept;
    logic wr_in_range;

    logic [CIW-1:0]    col_lo, col_hi;
    logic [RIW-1:0]    row_lo, row_hi;
    logic [FRAC_W-1:0] col_frac, row_frac;
    logic [CCW-1:0]    col_count;
    logic [RCW-1:0]    row_count;

    // The pipeline never stalls, so every start is taken.
    assign busy   = 1'b0;
    assign accept = start && !busy;
    // drop writes beyond the store
    assign wr_in_range = 32'(cell_index) < 32'(STORE_DEPTH);

    bhs_axis #(.MAX_N(MAX_COLS)) u_col_axis
    (
        .pos   (sample_col),
        .size  (raster_cols_reg),
        .lo    (col_lo),
        .hi    (col_hi),
        .frac  (col_frac),
        .count (col_count)
    );

    bhs_axis #(.MAX_N(MAX_ROWS)) u_row_axis
    (
        .pos   (sample_row),
        .size  (raster_rows_reg),
        .lo    (row_lo),
        .hi    (row_hi),
        .frac  (row_frac),
        .count (row_count)
    );

    // Stage 1: clamped cells, fractions and write payload
    logic                       s1_valid_reg;
    logic                       s1_wr_reg;
    logic [IDX_W-1:0]           s1_wr_addr_reg;
    logic signed [HEIGHT_W-1:0] s1_wr_data_reg;
    logic [CIW-1:0]             s1_c0_reg, s1_c1_reg;
    logic [RIW-1:0]             s1_r0_reg, s1_r1_reg;
    logic [FRAC_W-1:0]          s1_fx_reg, s1_fy_reg;

    always_ff @(posedge clk)
    begin
        s1_wr_addr_reg <= IDX_W'(cell_index);
        s1_wr_data_reg <= cell_height;
        s1_c0_reg      <= col_lo;
        s1_c1_reg      <= col_hi;
        s1_r0_reg      <= row_lo;
        s1_r1_reg      <= row_hi;
        s1_fx_reg      <= col_frac;
        s1_fy_reg      <= row_frac;
    end

    // ------------------------------------------------------------------
    // Stage 1: form row base addresses and weights, access the store.
    // Writes and reads both hit the store from this stage, so beats reach
    // it in order and a sample always sees every earlier write: no
    // forwarding path is needed.
    // ------------------------------------------------------------------
    logic [IDX_W-1:0] base_r0, base_r1;
    logic [WGT_W-1:0] wx_lo, wx_hi, wy_lo, wy_hi;

    always_comb
    begin
        base_r0 = IDX_W'(32'(s1_r0_reg) * 32'(col_count) + 32'(s1_c0_reg));
        base_r1 = IDX_W'(32'(s1_r1_reg) * 32'(col_count) + 32'(s1_c0_reg));
        wx_hi = WGT_W'(s1_fx_reg);
        wx_lo = WGT_ONE - wx_hi;
        wy_hi = WGT_W'(s1_fy_reg);
        wy_lo = WGT_ONE - wy_hi;
    end

    logic signed [HEIGHT_W-1:0] cell_raw [4];

    bhs_store #(.DEPTH(STORE_DEPTH)) u_store
    (
        .clk      (clk),
        .wr_en    (s1_wr_reg),
        .wr_addr  (s1_wr_addr_reg),
        .wr_data  (s1_wr_data_reg),
        .rd_en    (s1_valid_reg),
        .rd_base0 (base_r0),
        .rd_base1 (base_r1),
        .rd_step  (s1_c1_reg != s1_c0_reg),
        .rd_lo0   (cell_raw[0]),
        .rd_hi0   (cell_raw[1]),
        .rd_lo1   (cell_raw[2]),
        .rd_hi1   (cell_raw[3])
    );

    // Stage 2: cells out of the store, two-axis weights
    logic             s2_valid_reg;
    logic [WXY_W-1:0] s2_wxy_reg [4];

    always_ff @(posedge clk)
    begin
        s2_wxy_reg[0] <= WXY_W'(WXY_W'(wy_lo) * WXY_W'(wx_lo));
        s2_wxy_reg[1] <= WXY_W'(WXY_W'(wy_lo) * WXY_W'(wx_hi));
        s2_wxy_reg[2] <= WXY_W'(WXY_W'(wy_hi) * WXY_W'(wx_lo));
        s2_wxy_reg[3] <= WXY_W'(WXY_W'(wy_hi) * WXY_W'(wx_hi));
    end

    // ------------------------------------------------------------------
    // Stage 2: zero missing cells, weight each neighbor
    // ------------------------------------------------------------------
    logic signed [HEIGHT_W-1:0] cell_val [4];
    logic signed [WXY_W:0]      wxy_s    [4];

    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            if (cell_raw[i] == nodata_value_reg || cell_raw[i] < MIN_VALID)
                cell_val[i] = '0;
            else
                cell_val[i] = cell_raw[i];
            wxy_s[i] = signed'({1'b0, s2_wxy_reg[i]});
        end
    end

    logic                     s3_valid_reg;
    logic signed [PROD_W-1:0] s3_prod_reg [4];

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 4; i++)
            s3_prod_reg[i] <= PROD_W'(cell_val[i]) * PROD_W'(wxy_s[i]);
    end

    // ------------------------------------------------------------------
    // Stage 3: sum, round halves up, scale to 1/256 units
    // ------------------------------------------------------------------
    logic signed [SUM_W-1:0] blend_sum;

    always_comb
    begin
        blend_sum = SUM_W'(s3_prod_reg[0]) + SUM_W'(s3_prod_reg[1])
                  + SUM_W'(s3_prod_reg[2]) + SUM_W'(s3_prod_reg[3])
                  + ROUND_HALF;
    end

    logic                    done_reg;
    logic signed [OUT_W-1:0] height_out_reg;

    always_ff @(posedge clk)
    begin
        height_out_reg <= blend_sum[FRAC_W +: OUT_W];
    end

    // Pipeline control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s1_wr_reg    <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= accept && (req_type == REQ_SAMPLE);
            s1_wr_reg    <= accept && (req_type == REQ_WRITE) && wr_in_range;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            done_reg     <= s3_valid_reg;
        end
    end

    assign done       = done_reg;
    assign height_out = height_out_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_sample_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && req_type == REQ_SAMPLE) |-> ##4 done)
        else $error("sample beat produced no result");

    a_write_gives_none: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && req_type == REQ_WRITE) |-> ##4 !done)
        else $error("write beat produced a result");

    a_clamp_order: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg |-> ((s1_c0_reg <= s1_c1_reg) && (s1_r0_reg <= s1_r1_reg)))
        else $error("clamped low cell above high cell");

    a_clamp_span: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg |-> (((s1_c1_reg - s1_c0_reg) <= CIW'(1))
                          && ((s1_r1_reg - s1_r0_reg) <= RIW'(1))))
        else $error("neighbor cells more than one apart");

    a_cells_in_raster: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg |-> ((32'(s1_c1_reg) < 32'(col_count))
                          && (32'(s1_r1_reg) < 32'(row_count))))
        else $error("clamped cell beyond raster in use");

endmodule

`default_nettype wire

@@ rtl/bhs_axis.sv @@
// One-axis clamp for the height sampler: splits a fixed-point position into
// low and high cell and fraction, clamped to the raster size in use.
// Depends on bhs_pkg.
`default_nettype none

module bhs_axis
    import bhs_pkg::*;
#(
    parameter int MAX_N = MAX_COLS_DEF,
    localparam int IW = $clog2(MAX_N),
    localparam int CW = $clog2(MAX_N + 1)
)
(
    input  wire logic signed [POS_W-1:0] pos,
    input  wire logic [SIZE_W-1:0]       size,
    output logic [IW-1:0]                lo,
    output logic [IW-1:0]                hi,
    output logic [FRAC_W-1:0]            frac,
    output logic [CW-1:0]                count
);

    logic signed [AXIS_W-1:0] floor_s;
    logic signed [AXIS_W-1:0] ceil_s;
    logic signed [AXIS_W-1:0] count_s;
    logic signed [AXIS_W-1:0] last_s;
    logic signed [AXIS_W-1:0] hi_s;
    logic signed [AXIS_W-1:0] lo_s;
    logic [AXIS_W-1:0]        size_ext;

    always_comb
    begin
        frac     = pos[FRAC_W-1:0];
        floor_s  = AXIS_W'(signed'(pos[POS_W-1:FRAC_W]));
        ceil_s   = floor_s + signed'({{(AXIS_W-1){1'b0}}, (|frac)});

        // saturate the size register to 1..MAX_N
        size_ext = AXIS_W'(size);
        if (size == '0)
            count_s = AXIS_W'(1);
        else if (size_ext > AXIS_W'(MAX_N))
            count_s = AXIS_W'(MAX_N);
        else
            count_s = signed'(size_ext);
        last_s = count_s - AXIS_W'(1);

        hi_s = (ceil_s > last_s) ? last_s : ceil_s;
        if (hi_s < 0)
            hi_s = '0;
        lo_s = (floor_s < 0) ? '0 : floor_s;
        if (lo_s > hi_s)
            lo_s = hi_s;

        lo    = lo_s[IW-1:0];
        hi    = hi_s[IW-1:0];
        count = count_s[CW-1:0];
    end

endmodule

`default_nettype wire

@@ rtl/bhs_store.sv @@
// Raster store for the height sampler: two banks split on the cell index
// parity, each read at two addresses, so two adjacent cells of two rows
// come out of one access. Depends on bhs_pkg.
`default_nettype none

module bhs_store
    import bhs_pkg::*;
#(
    parameter int DEPTH = MAX_COLS_DEF * MAX_ROWS_DEF,
    localparam int IDX_W = $clog2(DEPTH)
)
(
    input  wire logic                        clk,
    input  wire logic                        wr_en,
    input  wire logic [IDX_W-1:0]            wr_addr,
    input  wire logic signed [HEIGHT_W-1:0]  wr_data,
    input  wire logic                        rd_en,
    input  wire logic [IDX_W-1:0]            rd_base0,
    input  wire logic [IDX_W-1:0]            rd_base1,
    input  wire logic                        rd_step,
    output logic signed [HEIGHT_W-1:0]       rd_lo0,
    output logic signed [HEIGHT_W-1:0]       rd_hi0,
    output logic signed [HEIGHT_W-1:0]       rd_lo1,
    output logic signed [HEIGHT_W-1:0]       rd_hi1
);

    localparam int BANK_DEPTH = (DEPTH + 1) / 2;
    localparam int BAW = $clog2(BANK_DEPTH);

    logic signed [HEIGHT_W-1:0] even_mem [BANK_DEPTH];
    logic signed [HEIGHT_W-1:0] odd_mem  [BANK_DEPTH];

    logic [BAW-1:0] wr_bank_addr;
    logic [BAW-1:0] oa0, oa1, ea0, ea1;
    logic [BAW:0]   ea0_wide, ea1_wide;

    logic signed [HEIGHT_W-1:0] even0_reg, even1_reg, odd0_reg, odd1_reg;
    logic                       par0_reg, par1_reg, step_reg;
    logic signed [HEIGHT_W-1:0] cur0, nxt0, cur1, nxt1;

    always_comb
    begin
        wr_bank_addr = BAW'(wr_addr >> 1);
        oa0 = BAW'(rd_base0 >> 1);
        oa1 = BAW'(rd_base1 >> 1);
        // an odd base finds its right neighbor in the next even entry
        ea0_wide = (BAW+1)'(oa0) + (BAW+1)'(rd_base0[0]);
        ea1_wide = (BAW+1)'(oa1) + (BAW+1)'(rd_base1[0]);
        ea0 = (ea0_wide >= (BAW+1)'(BANK_DEPTH)) ? '0 : ea0_wide[BAW-1:0];
        ea1 = (ea1_wide >= (BAW+1)'(BANK_DEPTH)) ? '0 : ea1_wide[BAW-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (wr_en && !wr_addr[0])
            even_mem[wr_bank_addr] <= wr_data;
        if (rd_en)
        begin
            even0_reg <= even_mem[ea0];
            even1_reg <= even_mem[ea1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en && wr_addr[0])
            odd_mem[wr_bank_addr] <= wr_data;
        if (rd_en)
        begin
            odd0_reg <= odd_mem[oa0];
            odd1_reg <= odd_mem[oa1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            par0_reg <= rd_base0[0];
            par1_reg <= rd_base1[0];
            step_reg <= rd_step;
        end
    end

    always_comb
    begin
        cur0 = par0_reg ? odd0_reg  : even0_reg;
        nxt0 = par0_reg ? even0_reg : odd0_reg;
        cur1 = par1_reg ? odd1_reg  : even1_reg;
        nxt1 = par1_reg ? even1_reg : odd1_reg;
        rd_lo0 = cur0;
        rd_lo1 = cur1;
        // on a clamped axis both neighbors are the same cell
        rd_hi0 = step_reg ? nxt0 : cur0;
        rd_hi1 = step_reg ? nxt1 : cur1;
    end

endmodule

`default_nettype wire

@@ test/bhs_height_checker.sv @@
// Height checker for the bilinear height sampler: keeps its own raster copy
// and register set, predicts every sample beat and compares the results.
// Depends on bhs_pkg for widths, request codes, register indexes and resets.

module bhs_height_checker
    import bhs_pkg::*;
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       start,
    input  wire logic                       busy,
    input  wire logic                       req_type,
    input  wire logic [CELL_W-1:0]          cell_index,
    input  wire logic signed [HEIGHT_W-1:0] cell_height,
    input  wire logic signed [POS_W-1:0]    sample_col,
    input  wire logic signed [POS_W-1:0]    sample_row,
    input  wire logic                       cfg_we,
    input  wire logic [CFG_IDX_W-1:0]       cfg_index,
    input  wire logic [CFG_W-1:0]           cfg_data,
    input  wire logic                       done,
    input  wire logic signed [OUT_W-1:0]    height_out,
    output int                              fails,
    output int                              pending,
    output int                              checked
);

    localparam int UNIT       = 1 << FRAC_W;
    localparam int CELLS      = MAX_COLS_DEF * MAX_ROWS_DEF;
    localparam int REPORT_CAP = 40;

    logic signed [HEIGHT_W-1:0] height_copy [CELLS];
    logic [SIZE_W-1:0]          cols_reg;
    logic [SIZE_W-1:0]          rows_reg;
    logic signed [HEIGHT_W-1:0] nodata_reg;
    logic signed [OUT_W-1:0]    expected_heights [$];
    logic signed [OUT_W-1:0]    oldest;

    task automatic report_mismatch(input string msg);
        fails++;
        if (fails <= REPORT_CAP)
            $display("%0t: height check: %s", $time, msg);
    endtask

    function automatic int size_in_use(input logic [SIZE_W-1:0] word, input int limit);
        if (word == 0)
            return 1;
        if (int'(word) > limit)
            return limit;
        return int'(word);
    endfunction

    // Clamp one axis to the raster: low and high neighbor plus the fraction.
    function automatic void span_axis(input int pos, input int n,
                                      output int lo, output int hi, output int frac);
        int fl;
        frac = pos & (UNIT - 1);
        fl   = pos >>> FRAC_W;
        hi   = fl + ((frac != 0) ? 1 : 0);
        if (hi > n - 1)
            hi = n - 1;
        if (hi < 0)
            hi = 0;
        lo = (fl < 0) ? 0 : fl;
        if (lo > hi)
            lo = hi;
    endfunction

    // Missing or too-low heights count as zero.
    function automatic longint cell_level(input int col, input int row, input int n_cols);
        logic signed [HEIGHT_W-1:0] h;
        h = height_copy[row * n_cols + col];
        if (h == nodata_reg || h < MIN_VALID)
            return 0;
        return longint'(h);
    endfunction

    function automatic logic signed [OUT_W-1:0] blend_height(
        input logic signed [POS_W-1:0] col_pos,
        input logic signed [POS_W-1:0] row_pos);
        int     c0, c1, r0, r1, fx, fy, n_cols, n_rows;
        longint acc;
        n_cols = size_in_use(cols_reg, MAX_COLS_DEF);
        n_rows = size_in_use(rows_reg, MAX_ROWS_DEF);
        span_axis(int'(col_pos), n_cols, c0, c1, fx);
        span_axis(int'(row_pos), n_rows, r0, r1, fy);
        acc = longint'(UNIT - fy) * (UNIT - fx) * cell_level(c0, r0, n_cols)
            + longint'(UNIT - fy) * fx * cell_level(c1, r0, n_cols)
            + longint'(fy) * (UNIT - fx) * cell_level(c0, r1, n_cols)
            + longint'(fy) * fx * cell_level(c1, r1, n_cols);
        acc = (acc + UNIT / 2) >>> FRAC_W;
        return acc[OUT_W-1:0];
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cols_reg   <= SIZE_RESET;
            rows_reg   <= SIZE_RESET;
            nodata_reg <= NODATA_RESET;
            expected_heights.delete();
            pending    <= 0;
        end
        else
        begin
            if (done)
            begin
                if (expected_heights.size() == 0)
                    report_mismatch($sformatf("unexpected result %0d", height_out));
                else
                begin
                    oldest = expected_heights.pop_front();
                    checked++;
                    if (height_out !== oldest)
                        report_mismatch($sformatf("height_out %0d, predicted %0d",
                                                  height_out, oldest));
                end
            end
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_COLS:   cols_reg   <= cfg_data[SIZE_W-1:0];
                    REG_ROWS:   rows_reg   <= cfg_data[SIZE_W-1:0];
                    REG_NODATA: nodata_reg <= cfg_data[HEIGHT_W-1:0];
                    default:    ;
                endcase
            end
            if (start && !busy)
            begin
                if (req_type == REQ_WRITE)
                    height_copy[cell_index] <= cell_height;
                else
                    expected_heights.push_back(blend_height(sample_col, sample_row));
            end
            pending <= expected_heights.size();
        end
    end

endmodule

@@ test/tb.sv @@
// Top of the bilinear height sampler bench: clock, reset, stimulus, watchdog
// and verdict. Depends on bhs_pkg, bhs_height_checker and the sampler core.

module tb;
    import bhs_pkg::*;

    localparam int UNIT            = 1 << FRAC_W;
    localparam int CELLS           = MAX_COLS_DEF * MAX_ROWS_DEF;
    localparam int SETTLE_CYCLES   = 8;
    localparam int WATCH_LIMIT     = 2000;
    localparam int RANDOM_PHASES   = 12;
    localparam int BEATS_PER_PHASE = 48;
    localparam int EDGE_BAND       = 4;
    // Index 3 maps to no register; a write there must change nothing.
    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

    logic                       clk         = 1'b0;
    logic                       rst_n       = 1'b0;
    logic                       start       = 1'b0;
    logic                       busy;
    logic                       req_type    = REQ_WRITE;
    logic [CELL_W-1:0]          cell_index  = '0;
    logic signed [HEIGHT_W-1:0] cell_height = '0;
    logic signed [POS_W-1:0]    sample_col  = '0;
    logic signed [POS_W-1:0]    sample_row  = '0;
    logic                       cfg_we      = 1'b0;
    logic [CFG_IDX_W-1:0]       cfg_index   = REG_COLS;
    logic [CFG_W-1:0]           cfg_data    = '0;
    logic                       done;
    logic signed [OUT_W-1:0]    height_out;

    int fails;
    int pending;
    int checked;

    // Stimulus view of the current setting, used to aim beats at the raster.
    int                         idle_pct     = 0;
    int                         cols_now     = MAX_COLS_DEF;
    int                         rows_now     = MAX_ROWS_DEF;
    logic signed [HEIGHT_W-1:0] nodata_now   = NODATA_RESET;
    int                         write_beats  = 0;
    int                         sample_beats = 0;
    int                         settings     = 0;
    int                         stall_cycles = 0;
    // Cells loaded so far; a sample only goes out once all its neighbors are set.
    bit                         written [CELLS];

    bilinear_height_sampler_core i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .req_type    (req_type),
        .cell_index  (cell_index),
        .cell_height (cell_height),
        .sample_col  (sample_col),
        .sample_row  (sample_row),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .done        (done),
        .height_out  (height_out)
    );

    bhs_height_checker i_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .req_type    (req_type),
        .cell_index  (cell_index),
        .cell_height (cell_height),
        .sample_col  (sample_col),
        .sample_row  (sample_row),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .done        (done),
        .height_out  (height_out),
        .fails       (fails),
        .pending     (pending),
        .checked     (checked)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Watchdog: restart the count on every accepted beat, result or register
    // write; give up when the block goes quiet for too long.
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done || cfg_we)
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= WATCH_LIMIT)
        begin
            $display("Watchdog: nothing accepted for %0d cycles, %0d results outstanding",
                     stall_cycles, pending);
            $display("TB_ERROR");
            $finish;
        end
    end

    // Saturate a size word the way the block reads it (low 9 bits, 1..limit).
    function automatic int size_in_use(input logic [CFG_W-1:0] word, input int limit);
        int v;
        v = int'(word[SIZE_W-1:0]);
        if (v == 0)
            return 1;
        return (v > limit) ? limit : v;
    endfunction

    // Clamp one axis the way the block does: low and high neighbor cell.
    function automatic void axis_span(input logic signed [POS_W-1:0] pos, input int n,
                                      output int lo, output int hi);
        int p;
        int fl;
        p  = int'(pos);
        fl = p >>> FRAC_W;
        hi = fl + (((p & (UNIT - 1)) != 0) ? 1 : 0);
        if (hi > n - 1)
            hi = n - 1;
        if (hi < 0)
            hi = 0;
        lo = (fl < 0) ? 0 : fl;
        if (lo > hi)
            lo = hi;
    endfunction

    // Mix ordinary heights with the special ones: nodata, extremes and the
    // values on either side of the validity threshold.
    function automatic logic signed [HEIGHT_W-1:0] pick_height();
        case ($urandom_range(9))
            0:       return nodata_now;
            1:       return HEIGHT_W'(16'h8000);
            2:       return HEIGHT_W'(16'h7FFF);
            3:       return MIN_VALID;
            4:       return MIN_VALID - 16'sd1;
            5:       return HEIGHT_W'(int'($urandom_range(0, 16)) - 8);
            default: return HEIGHT_W'($urandom);
        endcase
    endfunction

    // Mostly in a narrow band at either end of the axis, with integer,
    // half-cell, outside and full-range positions; the band keeps the number
    // of cells to load small.
    function automatic logic signed [POS_W-1:0] pick_pos(input int n);
        int w;
        int c;
        w = (n < EDGE_BAND) ? n : EDGE_BAND;
        c = int'($urandom_range(0, w - 1));
        if ($urandom_range(1) != 0)
            c = n - 1 - c;
        case ($urandom_range(9))
            0:       return POS_W'($urandom);
            1:       return POS_W'(-int'($urandom_range(1, 4 * UNIT)));
            2:       return POS_W'((n - 1) * UNIT + int'($urandom_range(0, 4 * UNIT)));
            3:       return POS_W'(c * UNIT);
            4:       return POS_W'(c * UNIT + UNIT / 2);
            default: return POS_W'(c * UNIT + int'($urandom_range(0, UNIT - 1)));
        endcase
    endfunction

    // Present one beat after a random gap and hold it until accepted. Leave
    // start high on return so back-to-back beats need no second assignment.
    task automatic send_beat(input logic                       kind,
                             input logic [CELL_W-1:0]          idx,
                             input logic signed [HEIGHT_W-1:0] h,
                             input logic signed [POS_W-1:0]    col_pos,
                             input logic signed [POS_W-1:0]    row_pos);
        while (idle_pct != 0 && $urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start       <= 1'b1;
        req_type    <= kind;
        cell_index  <= idx;
        cell_height <= h;
        sample_col  <= col_pos;
        sample_row  <= row_pos;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        if (kind == REQ_WRITE)
            write_beats++;
        else
            sample_beats++;
    endtask

    // The unused fields of each beat carry random bits; the block must ignore them.
    task automatic write_cell(input int idx, input logic signed [HEIGHT_W-1:0] h);
        send_beat(REQ_WRITE, CELL_W'(idx), h, POS_W'($urandom), POS_W'($urandom));
        written[idx] = 1'b1;
    endtask

    // Load any neighbor of the coming sample that has never been written.
    task automatic load_neighbors(input logic signed [POS_W-1:0] col_pos,
                                  input logic signed [POS_W-1:0] row_pos);
        int c0, c1, r0, r1;
        int nbr [4];
        axis_span(col_pos, cols_now, c0, c1);
        axis_span(row_pos, rows_now, r0, r1);
        nbr[0] = r0 * cols_now + c0;
        nbr[1] = r0 * cols_now + c1;
        nbr[2] = r1 * cols_now + c0;
        nbr[3] = r1 * cols_now + c1;
        foreach (nbr[k])
            if (!written[nbr[k]])
                write_cell(nbr[k], pick_height());
    endtask

    task automatic request_sample(input logic signed [POS_W-1:0] col_pos,
                                  input logic signed [POS_W-1:0] row_pos);
        load_neighbors(col_pos, row_pos);
        send_beat(REQ_SAMPLE, CELL_W'($urandom), HEIGHT_W'($urandom), col_pos, row_pos);
    endtask

    // Drop start, hold until every predicted height has come back, then let
    // the pipeline run dry before anything else touches the block.
    task automatic drain_results();
        start <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES)
            @(posedge clk);
    endtask

    // Write all three registers back to back; optionally poke the spare index.
    task automatic set_config(input logic [CFG_W-1:0] cols_word,
                              input logic [CFG_W-1:0] rows_word,
                              input logic [CFG_W-1:0] nodata_word,
                              input bit               poke_spare);
        cfg_we    <= 1'b1;
        cfg_index <= REG_COLS;
        cfg_data  <= cols_word;
        @(posedge clk);
        cfg_index <= REG_ROWS;
        cfg_data  <= rows_word;
        @(posedge clk);
        cfg_index <= REG_NODATA;
        cfg_data  <= nodata_word;
        @(posedge clk);
        if (poke_spare)
        begin
            cfg_index <= REG_SPARE;
            cfg_data  <= CFG_W'($urandom);
            @(posedge clk);
        end
        cfg_we     <= 1'b0;
        cols_now   = size_in_use(cols_word, MAX_COLS_DEF);
        rows_now   = size_in_use(rows_word, MAX_ROWS_DEF);
        nodata_now = nodata_word;
        settings++;
    endtask

    // One random beat: about a third are writes, mostly into the raster in use.
    task automatic random_beat();
        int idx;
        if ($urandom_range(9) < 3)
        begin
            if ($urandom_range(3) != 0)
                idx = int'($urandom_range(0, rows_now - 1)) * cols_now
                    + int'($urandom_range(0, cols_now - 1));
            else
                idx = $urandom_range(0, CELLS - 1);
            write_cell(idx, pick_height());
        end
        else
            request_sample(pick_pos(cols_now), pick_pos(rows_now));
    endtask

    initial
    begin
        logic [CFG_W-1:0] cols_word;
        logic [CFG_W-1:0] rows_word;
        logic [CFG_W-1:0] nodata_word;

        repeat (2)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        set_config(CFG_W'(SIZE_RESET), CFG_W'(SIZE_RESET), CFG_W'(NODATA_RESET), 1'b0);

        // Directed: full-scale positive and negative blends.
        write_cell(0, 16'sh7FFF);
        write_cell(1, 16'sh7FFF);
        write_cell(MAX_COLS_DEF, 16'sh7FFF);
        write_cell(MAX_COLS_DEF + 1, 16'sh7FFF);
        request_sample(POS_W'(UNIT / 2), POS_W'(UNIT / 2));
        write_cell(2, MIN_VALID);
        write_cell(3, MIN_VALID);
        write_cell(MAX_COLS_DEF + 2, MIN_VALID);
        write_cell(MAX_COLS_DEF + 3, MIN_VALID);
        request_sample(POS_W'(2 * UNIT + 8'h40), POS_W'(1));
        // Nodata, just below the threshold and the most negative code: only
        // the last corner should contribute.
        write_cell(4, NODATA_RESET);
        write_cell(5, MIN_VALID - 16'sd1);
        write_cell(MAX_COLS_DEF + 4, 16'sh8000);
        write_cell(MAX_COLS_DEF + 5, 16'sd100);
        request_sample(POS_W'(4 * UNIT + UNIT - 1), POS_W'(UNIT - 1));
        // Negative blends between -1 and 0: half-way and just past cell 6.
        write_cell(6, -16'sd1);
        write_cell(7, 16'sd0);
        request_sample(POS_W'(6 * UNIT + UNIT / 2), POS_W'(0));
        request_sample(POS_W'(6 * UNIT + 1), POS_W'(0));
        // Far outside on both sides, the origin and the last cell.
        request_sample(POS_W'(24'h800000), POS_W'(24'h7FFFFF));
        request_sample(POS_W'(24'h7FFFFF), POS_W'(24'h800000));
        request_sample(POS_W'(0), POS_W'(0));
        write_cell(CELLS - 1, -16'sd5);
        request_sample(POS_W'((MAX_COLS_DEF - 1) * UNIT), POS_W'((MAX_ROWS_DEF - 1) * UNIT));
        request_sample(POS_W'((MAX_COLS_DEF - 1) * UNIT + UNIT / 2),
                       POS_W'((MAX_ROWS_DEF - 1) * UNIT + UNIT / 2));

        // Random phases, each under its own register setting and idle mix.
        for (int phase = 1; phase <= RANDOM_PHASES; phase++)
        begin
            drain_results();
            case (phase)
                1:
                begin
                    cols_word = 16'd1;
                    rows_word = 16'd1;
                    nodata_word = 16'h8000;
                end
                2:
                begin
                    cols_word = 16'd0;
                    rows_word = 16'd2;
                    nodata_word = 16'h7FFF;
                end
                3:
                begin
                    cols_word = 16'd2;
                    rows_word = 16'd2;
                    nodata_word = 16'd0;
                end
                4:
                begin
                    cols_word = 16'd511;
                    rows_word = 16'd1;
                    nodata_word = CFG_W'($urandom);
                end
                5:
                begin
                    cols_word = 16'd1;
                    rows_word = 16'hFE00 | 16'd300;
                    nodata_word = CFG_W'($urandom);
                end
                6:
                begin
                    cols_word = 16'd5;
                    rows_word = 16'd3;
                    nodata_word = CFG_W'(MIN_VALID);
                end
                7:
                begin
                    cols_word = 16'd17;
                    rows_word = 16'd9;
                    nodata_word = CFG_W'($urandom);
                end
                8:
                begin
                    cols_word = 16'hFE00 | 16'd256;
                    rows_word = 16'd256;
                    nodata_word = CFG_W'($urandom);
                end
                default:
                begin
                    cols_word = {7'($urandom), 9'($urandom_range(1, 24))};
                    rows_word = {7'($urandom), 9'($urandom_range(1, 24))};
                    nodata_word = CFG_W'($urandom);
                end
            endcase
            set_config(cols_word, rows_word, nodata_word, phase == 3);

            case (phase % 3)
                0:       idle_pct = 0;
                1:       idle_pct = 60;
                default: idle_pct = 16;
            endcase

            for (int n = 0; n < BEATS_PER_PHASE; n++)
            begin
                // Now and then hold the sender until the pipeline is empty.
                if ($urandom_range(39) == 0)
                    drain_results();
                random_beat();
            end
        end

        drain_results();
        $display("Covered %0d write beats and %0d sample beats over %0d register settings.",
                 write_beats, sample_beats, settings);
        $display("Compared %0d heights, %0d mismatches.", checked, fails);
        if (fails == 0 && pending == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
